// ===== rtl/sfp_pkg.sv =====
// Shared types and constants for the SysEx frame parser.
package sfp_pkg;

    // Framing bytes
    localparam logic [7:0] SOF_BYTE = 8'hF0;
    localparam logic [7:0] EOF_BYTE = 8'hF7;

    // Result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    // Error causes
    localparam logic [1:0] CAUSE_NONE  = 2'd0;
    localparam logic [1:0] CAUSE_START = 2'd1;
    localparam logic [1:0] CAUSE_END   = 2'd2;
    localparam logic [1:0] CAUSE_HDR   = 2'd3;

    // Configuration register indexes
    localparam int         CFG_IDX_BITS = 2;
    localparam logic [1:0] CFG_USE_MFR  = 2'd0;
    localparam logic [1:0] CFG_USE_DEV  = 2'd1;
    localparam logic [1:0] CFG_USE_SUB  = 2'd2;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload;
        logic [1:0]  cause;
        logic [15:0] mfr;
        logic [7:0]  dev;
        logic [7:0]  sub;
        logic [15:0] count;
    } t_result;

endpackage

// ===== rtl/sysex_frame_parser.sv =====
// Top level of the streaming MIDI system-exclusive frame parser.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_byte, i_last_byte
//  out     | output    | o_out_valid / i_out_stall | o_out_kind .. o_payload_count
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One byte is taken per cycle while o_in_stall is low; its result (if any) is registered
// and shows on the out channel in the next cycle unless a result is still held there. A
// two-entry output buffer lets input continue while one result waits; o_in_stall rises
// only when both entries are held. Reset is synchronous; no clearing pass.
// Configuration writes are always accepted (o_cfg_ready is tied high).
module sysex_frame_parser #(
    parameter int COUNT_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // byte input
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_in_byte,
    input  logic                             i_last_byte,
    // result output
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_out_kind,
    output logic [7:0]                       o_payload_byte,
    output logic [1:0]                       o_error_cause,
    output logic [15:0]                      o_mfr_id,
    output logic [7:0]                       o_dev_id,
    output logic [7:0]                       o_sub_id,
    output logic [15:0]                      o_payload_count,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sfp_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic                             i_cfg_data
);

    // Parse phases
    localparam logic [2:0] PH_START   = 3'd0;
    localparam logic [2:0] PH_MFR     = 3'd1;
    localparam logic [2:0] PH_MFR_HI  = 3'd2;
    localparam logic [2:0] PH_MFR_LO  = 3'd3;
    localparam logic [2:0] PH_DEV     = 3'd4;
    localparam logic [2:0] PH_SUB     = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;
    localparam logic [2:0] PH_DRAIN   = 3'd7;

    logic                  r_use_mfr;
    logic                  r_use_dev;
    logic                  r_use_sub;
    logic [2:0]            r_phase;
    logic [2:0]            n_phase;
    logic [15:0]           r_mfr;
    logic [15:0]           n_mfr;
    logic [7:0]            r_dev;
    logic [7:0]            n_dev;
    logic [7:0]            r_sub;
    logic [7:0]            n_sub;
    logic [COUNT_BITS-1:0] r_tally;
    logic [COUNT_BITS-1:0] n_tally;
    logic [15:0]           w_count;
    logic                  w_accept;
    logic                  w_has_res;
    logic                  w_full;
    sfp_pkg::t_result      w_res;
    sfp_pkg::t_result      w_out;

    assign w_accept    = i_in_valid && !w_full;
    assign o_in_stall  = w_full;
    assign o_cfg_ready = 1'b1;

    // Shown count saturates at 16 bits
    generate
        if (COUNT_BITS > 16) begin : g_cnt_sat
            assign w_count = (|r_tally[COUNT_BITS-1:16]) ? 16'hFFFF : r_tally[15:0];
        end else begin : g_cnt_ext
            assign w_count = 16'(r_tally);
        end
    endgenerate

    // First enabled header phase at or after the given one
    function automatic logic [2:0] phase_from(input logic [2:0] p, input logic use_mfr,
                                              input logic use_dev, input logic use_sub);
        logic [2:0] r;
        r = PH_PAYLOAD;
        if (p <= PH_SUB && use_sub) r = PH_SUB;
        if (p <= PH_DEV && use_dev) r = PH_DEV;
        if (p <= PH_MFR && use_mfr) r = PH_MFR;
        return r;
    endfunction

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_mfr <= 1'b1;
            r_use_dev <= 1'b1;
            r_use_sub <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sfp_pkg::CFG_USE_MFR: r_use_mfr <= i_cfg_data;
                sfp_pkg::CFG_USE_DEV: r_use_dev <= i_cfg_data;
                sfp_pkg::CFG_USE_SUB: r_use_sub <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state and result for the byte at the input
    always_comb begin
        n_phase   = r_phase;
        n_mfr     = r_mfr;
        n_dev     = r_dev;
        n_sub     = r_sub;
        n_tally   = r_tally;
        w_has_res = 1'b0;
        w_res     = '0;
        w_res.mfr   = r_mfr;
        w_res.dev   = r_dev;
        w_res.sub   = r_sub;
        w_res.count = w_count;
        if (i_last_byte) begin
            w_has_res = 1'b1;
            if (r_phase == PH_START || r_phase == PH_DRAIN) begin
                w_res.kind  = sfp_pkg::KIND_BAD;
                w_res.cause = sfp_pkg::CAUSE_START;
            end else if (i_in_byte != sfp_pkg::EOF_BYTE) begin
                w_res.kind  = sfp_pkg::KIND_BAD;
                w_res.cause = sfp_pkg::CAUSE_END;
            end else if (r_phase != PH_PAYLOAD) begin
                w_res.kind  = sfp_pkg::KIND_BAD;
                w_res.cause = sfp_pkg::CAUSE_HDR;
            end else begin
                w_res.kind  = sfp_pkg::KIND_OK;
                w_res.cause = sfp_pkg::CAUSE_NONE;
            end
            // back to start with held values cleared
            n_phase = PH_START;
            n_mfr   = '0;
            n_dev   = '0;
            n_sub   = '0;
            n_tally = '0;
        end else begin
            case (r_phase)
                PH_START: begin
                    if (i_in_byte != sfp_pkg::SOF_BYTE) begin
                        n_phase = PH_DRAIN;
                    end else begin
                        n_phase = phase_from(PH_MFR, r_use_mfr, r_use_dev, r_use_sub);
                    end
                end
                PH_MFR: begin
                    n_mfr   = {8'h00, i_in_byte};
                    n_phase = (i_in_byte == 8'h00) ? PH_MFR_HI
                            : phase_from(PH_DEV, r_use_mfr, r_use_dev, r_use_sub);
                end
                PH_MFR_HI: begin
                    n_mfr   = {i_in_byte, 8'h00};
                    n_phase = PH_MFR_LO;
                end
                PH_MFR_LO: begin
                    n_mfr   = {r_mfr[15:8], i_in_byte};
                    n_phase = phase_from(PH_DEV, r_use_mfr, r_use_dev, r_use_sub);
                end
                PH_DEV: begin
                    n_dev   = i_in_byte;
                    n_phase = phase_from(PH_SUB, r_use_mfr, r_use_dev, r_use_sub);
                end
                PH_SUB: begin
                    n_sub   = i_in_byte;
                    n_phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (r_tally != '1) begin
                        n_tally = r_tally + COUNT_BITS'(1);
                    end
                    w_has_res     = 1'b1;
                    w_res         = '0;
                    w_res.kind    = sfp_pkg::KIND_DATA;
                    w_res.payload = i_in_byte;
                end
                default: ;
            endcase
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_mfr   <= '0;
            r_dev   <= '0;
            r_sub   <= '0;
            r_tally <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_mfr   <= n_mfr;
            r_dev   <= n_dev;
            r_sub   <= n_sub;
            r_tally <= n_tally;
        end
    end

    // Result buffer
    sfp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept && w_has_res),
        .i_data  (w_res),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (w_out)
    );

    assign o_out_kind      = w_out.kind;
    assign o_payload_byte  = w_out.payload;
    assign o_error_cause   = w_out.cause;
    assign o_mfr_id        = w_out.mfr;
    assign o_dev_id        = w_out.dev;
    assign o_sub_id        = w_out.sub;
    assign o_payload_count = w_out.count;

    // Every final byte returns the parser to the start phase with a clean tally
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last_byte) |=> (r_phase == PH_START && r_tally == '0))
        else $error("final byte did not clear parser state");

endmodule

// ===== rtl/sfp_out_buf.sv =====
// Two-entry output buffer (output register plus skid register) for parser results.
module sfp_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sfp_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output sfp_pkg::t_result o_data
);

    logic             r_out_valid;
    logic             r_skid_valid;
    sfp_pkg::t_result r_out;
    sfp_pkg::t_result r_skid;
    logic             w_pop;

    assign w_pop   = r_out_valid && !i_stall;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_full  = r_skid_valid;

    // Control: skid only fills when the output register is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Data path
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_pop) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    // Skid entry never exists without a held output entry
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry without output entry");

    // Upstream never pushes into a full buffer
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_skid_valid))
        else $error("push while buffer full");

    // A stalled full buffer keeps its skid entry
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_stall) |=> r_skid_valid)
        else $error("skid entry lost under stall");

endmodule
